/* src/sws_pkg.sv */
// Shared types and constants for the stopwatch display core.
// No dependencies; imported by the digit cell and the top level.
package sws_pkg;

    localparam int unsigned CountW    = 20;
    localparam int unsigned DigitW    = 4;
    localparam int unsigned DigitSlots = 8;

    localparam logic [CountW-1:0] TargetMin   = 20'd1;
    localparam logic [CountW-1:0] TargetMax   = 20'd1000000;
    localparam logic [CountW-1:0] TargetReset = 20'd1270;

    localparam logic [DigitW-1:0] DigitMax = 4'd9;
    localparam logic [3:0]        MinLen   = 4'd3;
    localparam logic [3:0]        DpPos    = 4'd3;

    typedef struct packed {
        logic advance;
    } item_t;

    typedef struct packed {
        logic [3:0]        digit_position;
        logic [DigitW-1:0] digit_value;
        logic              decimal_point;
        logic              last_digit;
    } result_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

endpackage

/* src/sws_stream_if.sv */
// Valid/ready stream channel carrying one payload beat.
// Payload type is set by the user; no other dependencies.
interface sws_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* src/sws_digit_cell.sv */
// One BCD digit cell: counting digit with carry to the next cell, plus a
// shadow digit that shifts toward position one while digits are sent. Uses sws_pkg.
module sws_digit_cell
    import sws_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctrl_t        ctrl,
    input  logic              carry_in,
    input  logic [DigitW-1:0] shift_in,
    output logic              carry_out,
    output logic [DigitW-1:0] digit,
    output logic [DigitW-1:0] shadow_out
);

    logic [DigitW-1:0] digit_reg, digit_next;
    logic [DigitW-1:0] shadow_reg, shadow_next;

    always_comb
    begin
        digit_next = digit_reg;
        if (carry_in)
        begin
            digit_next = (digit_reg == DigitMax) ? '0 : digit_reg + 4'd1;
        end
    end

    always_comb
    begin
        shadow_next = shadow_reg;
        if (ctrl.load)
        begin
            shadow_next = digit_reg;
        end
        else if (ctrl.shift)
        begin
            shadow_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_reg <= '0;
        end
        else
        begin
            shadow_reg <= shadow_next;
        end
    end

    assign carry_out  = carry_in && (digit_reg == DigitMax);
    assign digit      = digit_reg;
    assign shadow_out = shadow_reg;

endmodule

/* src/stopwatch_seven_segment_display_core.sv */
// Stopwatch display core: accepted item -> count update, load of the shadow digits,
// then one digit beat per cycle while result is ready (n beats, 3..MAX_DIGITS).
// The digit count n and the shared position counter set the item time; an item
// taken while halted finishes in its accept cycle with no beats.
// Reset (rst_n, async, active low): count and digits zero, running, target 1270.
// Depends on sws_pkg, sws_stream_if and sws_digit_cell.
module stopwatch_seven_segment_display_core
    import sws_pkg::*;
#(
    parameter int unsigned MAX_DIGITS = 7
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CountW-1:0]         cfg_wdata,
    sws_stream_if.sink                item,
    sws_stream_if.source              result
);

    localparam logic [3:0] MaxLen = 4'(MAX_DIGITS);

    state_t            state_reg, state_next;
    logic [CountW-1:0] target_reg;
    logic [CountW-1:0] count_reg, count_next;
    logic              halted_reg, halted_next;
    logic [3:0]        pos_reg, pos_next;
    logic [3:0]        len_reg, len_next;
    logic [CountW-1:0] target_eff;
    logic              item_beat, result_beat, step;
    logic [3:0]        len_calc;
    cell_ctrl_t        cell_ctrl;

    logic [DigitSlots:0]  carry;
    logic [DigitW-1:0]    digit   [DigitSlots];
    logic [DigitW-1:0]    shadow  [DigitSlots+1];

    assign item_beat   = item.valid && item.ready;
    assign result_beat = result.valid && result.ready;
    assign step        = item_beat && !halted_reg && item.payload.advance;

    assign carry[0]               = step;
    assign shadow[DigitSlots]     = '0;
    assign cell_ctrl.load         = (state_reg == ST_LOAD);
    assign cell_ctrl.shift        = result_beat;

    for (genvar g = 0; g < DigitSlots; g++)
    begin : g_cell
        sws_digit_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .carry_in   (carry[g]),
            .shift_in   (shadow[g+1]),
            .carry_out  (carry[g+1]),
            .digit      (digit[g]),
            .shadow_out (shadow[g])
        );
    end

    always_comb
    begin
        if (target_reg < TargetMin)
        begin
            target_eff = TargetMin;
        end
        else if (target_reg > TargetMax)
        begin
            target_eff = TargetMax;
        end
        else
        begin
            target_eff = target_reg;
        end
    end

    // displayed length: highest nonzero digit, clamped to MinLen..MaxLen
    always_comb
    begin
        len_calc = '0;
        for (int i = 0; i < DigitSlots; i++)
        begin
            if (digit[i] != '0)
            begin
                len_calc = 4'(i + 1);
            end
        end
        if (len_calc < MinLen)
        begin
            len_calc = MinLen;
        end
        if (len_calc > MaxLen)
        begin
            len_calc = MaxLen;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        halted_next = halted_reg;
        pos_next    = pos_reg;
        len_next    = len_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_beat && !halted_reg)
                begin
                    count_next = count_reg + CountW'(item.payload.advance);
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (count_reg >= target_eff)
                begin
                    halted_next = 1'b1;
                end
                len_next   = len_calc;
                pos_next   = 4'd1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (result_beat)
                begin
                    pos_next = pos_reg + 4'd1;
                    if (pos_reg == len_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            target_reg <= TargetReset;
            count_reg  <= '0;
            halted_reg <= 1'b0;
            pos_reg    <= 4'd1;
            len_reg    <= MinLen;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            halted_reg <= halted_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            if (cfg_we)
            begin
                target_reg <= cfg_wdata;
            end
        end
    end

    assign item.ready                    = (state_reg == ST_IDLE);
    assign result.valid                  = (state_reg == ST_EMIT);
    assign result.payload.digit_position = pos_reg;
    assign result.payload.digit_value    = shadow[0];
    assign result.payload.decimal_point  = (pos_reg == DpPos);
    assign result.payload.last_digit     = (pos_reg == len_reg);

`ifndef SYNTHESIS
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (pos_reg >= 4'd1) && (pos_reg <= len_reg))
        else $error("digit position outside displayed length");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        result_beat && result.payload.last_digit |=> !result.valid && item.ready)
        else $error("digit beats continue after the last digit");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= TargetMax)
        else $error("count passed the largest target");

    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg && item.ready |=> !result.valid)
        else $error("digit beat issued while halted");
`endif

endmodule

/* tb/tb.sv */
// Self-checking testbench for stopwatch_seven_segment_display_core.
// Drives count/refresh beats and target writes, predicts every digit write.
// Depends on sws_pkg, sws_stream_if and the core RTL.
`timescale 1ns / 100ps

module tb
    import sws_pkg::*;
();

    localparam int ShownMax     = 7;     // MAX_DIGITS of the instance
    localparam int SettleCycles = 16;    // quiet time after the last digit write
    localparam int StallLimit   = 2000;  // cycles with no beat at all
    localparam int PhaseItems   = 62;
    localparam int DirRows      = 23;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    // typed_n < 0: expectation comes from the stopwatch model below
    typedef struct {
        row_kind_t   kind;
        logic [19:0] value;
        int          typed_n;
        logic [27:0] typed_digits;
    } stim_row_t;

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we;
    logic [CountW-1:0] cfg_wdata;

    sws_stream_if #(.payload_t(item_t))   item_ch ();
    sws_stream_if #(.payload_t(result_t)) result_ch ();

    stopwatch_seven_segment_display_core #(
        .MAX_DIGITS(ShownMax)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (result_ch)
    );

    always #2 clk = ~clk;

    // stopwatch model state
    logic [CountW-1:0] watch_count;
    logic [CountW-1:0] watch_target;
    logic              watch_halted;

    result_t     digit_writes_due[$];
    int unsigned mismatches  = 0;
    int unsigned beats_seen  = 0;
    int unsigned items_sent  = 0;
    int unsigned rx_wait     = 0;
    int unsigned rx_hold     = 0;
    logic        hold_done   = 1'b0;
    int unsigned idle_cycles = 0;

    stim_row_t dir_rows [0:DirRows-1] = '{
        '{ROW_ITEM, 20'd0,       3,  28'h0000000},  // refresh right after reset
        '{ROW_CFG,  20'd1,       -1, 28'h0},        // minimum target
        '{ROW_ITEM, 20'd0,       3,  28'h0000000},  // 0 < 1, keeps running
        '{ROW_CFG,  20'hFFFFF,   -1, 28'h0},        // above max, saturates
        '{ROW_ITEM, 20'd1,       3,  28'h0000001},
        '{ROW_ITEM, 20'd1,       -1, 28'h0},
        '{ROW_ITEM, 20'd1,       -1, 28'h0},
        '{ROW_ITEM, 20'd0,       -1, 28'h0},
        '{ROW_ITEM, 20'd1,       -1, 28'h0},
        '{ROW_ITEM, 20'd1,       -1, 28'h0},
        '{ROW_ITEM, 20'd1,       -1, 28'h0},
        '{ROW_ITEM, 20'd1,       -1, 28'h0},
        '{ROW_ITEM, 20'd1,       -1, 28'h0},
        '{ROW_ITEM, 20'd1,       -1, 28'h0},
        '{ROW_ITEM, 20'd1,       -1, 28'h0},
        '{ROW_ITEM, 20'd0,       -1, 28'h0},
        '{ROW_ITEM, 20'd1,       -1, 28'h0},        // count 11, tens digit
        '{ROW_CFG,  20'd1000000, -1, 28'h0},        // maximum target
        '{ROW_ITEM, 20'd1,       -1, 28'h0},
        '{ROW_ITEM, 20'd1,       -1, 28'h0},
        '{ROW_ITEM, 20'd0,       -1, 28'h0},
        '{ROW_ITEM, 20'd1,       -1, 28'h0},
        '{ROW_ITEM, 20'd1,       -1, 28'h0}
    };

    // Count/halt update for one accepted beat; returns digits shown (0 if halted).
    function automatic void tick_watch(input logic adv, output int n,
                                       output logic [27:0] digs);
        logic [CountW-1:0] limit;
        logic [CountW-1:0] v;
        int                len;
        n    = 0;
        digs = '0;
        if (watch_halted)
            return;
        if (adv)
            watch_count = watch_count + 1'b1;
        limit = watch_target;
        if (limit < TargetMin)
            limit = TargetMin;
        if (limit > TargetMax)
            limit = TargetMax;
        if (watch_count >= limit)
            watch_halted = 1'b1;
        v   = watch_count;
        len = 0;
        for (int i = 0; i < DigitSlots; i++)
        begin
            if (i < ShownMax)
                digs[4*i +: 4] = 4'(v % 10);
            if (v != 0)
                len = i + 1;
            v = CountW'(v / 10);
        end
        if (len < MinLen)
            len = int'(MinLen);
        if (len > ShownMax)
            len = ShownMax;
        n = len;
    endfunction

    task automatic offer(input logic adv, input int typed_n, input logic [27:0] typed_digits);
        int unsigned gap;
        int          n;
        logic [27:0] digs;
        result_t     w;
        gap = ((items_sent / 40) % 4 == 2) ? 0 : $urandom_range(0, 16);
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid           <= 1'b1;
        item_ch.payload.advance <= adv;
        do
            @(posedge clk);
        while (!item_ch.ready);
        items_sent++;
        tick_watch(adv, n, digs);
        if (typed_n >= 0)
        begin
            n    = typed_n;
            digs = typed_digits;
        end
        for (int i = 0; i < n; i++)
        begin
            w.digit_position = 4'(i + 1);
            w.digit_value    = digs[4*i +: 4];
            w.decimal_point  = (i + 1 == DpPos);
            w.last_digit     = (i == n - 1);
            digit_writes_due.push_back(w);
        end
    endtask

    // hold the sender until every digit write is back and the core is quiet
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (digit_writes_due.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_target(input logic [CountW-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        watch_target = value;
    endtask

    initial
    begin
        item_ch.valid   = 1'b0;
        item_ch.payload = '0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        watch_count     = '0;
        watch_target    = TargetReset;
        watch_halted    = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DirRows; r++)
        begin
            if (dir_rows[r].kind == ROW_CFG)
                write_target(dir_rows[r].value);
            else
                offer(dir_rows[r].value[0], dir_rows[r].typed_n, dir_rows[r].typed_digits);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            for (int k = 0; k < PhaseItems; k++)
                offer($urandom_range(0, 3) != 0, -1, '0);
            // keep well above the count so the watch stays running
            if (ph < 3)
                write_target(CountW'($urandom_range(20'hFFFFF, watch_count + 400)));
        end

        // target dropped below the count: next beat halts, the rest are ignored
        write_target('0);
        offer(1'b1, -1, '0);
        offer(1'b1, -1, '0);
        offer(1'b0, -1, '0);
        for (int k = 0; k < 6; k++)
            offer(1'($urandom_range(0, 1)), -1, '0);
        settle();

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
    begin : digit_sink
        result_t     want;
        int unsigned wait_n;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            wait_n = rx_wait;
            if (result_ch.valid && result_ch.ready)
            begin
                beats_seen++;
                if (digit_writes_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected digit write pos=%0d val=%0d dp=%0b last=%0b",
                             $time, result_ch.payload.digit_position,
                             result_ch.payload.digit_value, result_ch.payload.decimal_point,
                             result_ch.payload.last_digit);
                end
                else
                begin
                    want = digit_writes_due.pop_front();
                    if (want.digit_position !== result_ch.payload.digit_position ||
                        want.digit_value !== result_ch.payload.digit_value ||
                        want.decimal_point !== result_ch.payload.decimal_point ||
                        want.last_digit !== result_ch.payload.last_digit)
                    begin
                        mismatches++;
                        $display("%0t: digit write expected pos=%0d val=%0d dp=%0b last=%0b",
                                 $time, want.digit_position, want.digit_value,
                                 want.decimal_point, want.last_digit);
                        $display("%0t: digit write actual   pos=%0d val=%0d dp=%0b last=%0b",
                                 $time, result_ch.payload.digit_position,
                                 result_ch.payload.digit_value,
                                 result_ch.payload.decimal_point,
                                 result_ch.payload.last_digit);
                    end
                end
                wait_n = ((beats_seen / 50) % 4 == 1) ? 0 : $urandom_range(0, 16);
                // one long back-pressure stretch so the input side fills and stalls
                if (!hold_done && beats_seen == 300)
                begin
                    rx_hold   = 250;
                    hold_done = 1'b1;
                end
            end
            if (rx_hold != 0)
            begin
                rx_hold--;
                rx_wait = wait_n;
                result_ch.ready <= 1'b0;
            end
            else if (wait_n != 0)
            begin
                rx_wait = wait_n - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                rx_wait = 0;
                result_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == StallLimit)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

/* sim.f */
src/sws_pkg.sv
src/sws_stream_if.sv
src/sws_digit_cell.sv
src/stopwatch_seven_segment_display_core.sv
tb/tb.sv
